### rtl/flru_pkg.sv
// ----------------------------------------------------------------------------
// flru_pkg: shared types for the fully associative lru tag core
// Request and response payloads plus the control and status groups that
// pass between the top level and the row of way cells.
// ----------------------------------------------------------------------------
package flru_pkg;

   // access kinds
   localparam logic KIND_INST = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   // request payload: one access
   typedef struct packed {
      logic        kind;
      logic [31:0] address;
   } req_type;

   // response payload: lookup outcome and running totals
   typedef struct packed {
      logic        hit;
      logic [1:0]  way;
      logic [31:0] access_total;
      logic [31:0] inst_hit_total;
      logic [31:0] data_hit_total;
      logic [31:0] miss_total;
   } rsp_type;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic lookup;   // compare the incoming tag this cycle
      logic commit;   // apply the update for the access in flight
      logic hit;      // some cell matched the access in flight
   } cell_ctl_type;

   // status from one cell
   typedef struct packed {
      logic match;    // registered tag match for the access in flight
      logic touch;    // this way is the one hit or filled
   } cell_stat_type;

endpackage

### rtl/flru_cell.sv
// ----------------------------------------------------------------------------
// flru_cell: one way of the fully associative tag array
// Holds tag, valid bit and lru rank for one way. Compares the broadcast tag,
// then on commit ages itself or becomes most recent, taking a fill on a miss.
// ----------------------------------------------------------------------------
module flru_cell
   import flru_pkg::*;
#(
   parameter int WAYS      = 4,
   parameter int INDEX     = 0,
   parameter int TAG_BITS  = 28,
   parameter int RANK_BITS = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctl_type         ctl,
   input  logic [TAG_BITS-1:0]  lookup_tag,
   input  logic [TAG_BITS-1:0]  fill_tag,
   input  logic [RANK_BITS-1:0] touch_rank,
   output cell_stat_type        stat,
   output logic [RANK_BITS-1:0] rank
);

   localparam logic [RANK_BITS-1:0] RANK_LAST  = RANK_BITS'(WAYS - 1);
   localparam logic [RANK_BITS-1:0] RANK_RESET = RANK_BITS'(WAYS - 1 - INDEX);

   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic                 valid_ff, valid_in;
   logic [RANK_BITS-1:0] rank_ff, rank_in;
   logic                 match_ff, match_in;
   logic                 touch;

   // hit way, or least recent way on a miss
   assign touch = match_ff | (~ctl.hit & (rank_ff == RANK_LAST));

   assign stat.match = match_ff;
   assign stat.touch = touch;
   assign rank       = rank_ff;

   // next state of the way
   always_comb begin
      tag_in   = tag_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      match_in = match_ff;
      if (ctl.lookup) begin
         match_in = valid_ff && (tag_ff == lookup_tag);
      end
      if (ctl.commit) begin
         if (touch) begin
            rank_in = '0;
            if (!ctl.hit) begin
               tag_in   = fill_tag;
               valid_in = 1'b1;
            end
         end else if (rank_ff < touch_rank) begin
            rank_in = rank_ff + RANK_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= '0;
         valid_ff <= 1'b0;
         rank_ff  <= RANK_RESET;
         match_ff <= 1'b0;
      end else begin
         tag_ff   <= tag_in;
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         match_ff <= match_in;
      end
   end

endmodule

### rtl/fully_associative_lru_cache_tags_core.sv
// ----------------------------------------------------------------------------
// fully_associative_lru_cache_tags_core: tag and true lru replacement logic
// A row of way cells compares the access tag, then the hit way (or the least
// recent way, filled on a miss) becomes most recent. Four wrapping counters
// keep access, instruction hit, data hit and miss totals.
//
//   channel  direction  ports                          payload
//   req      in         req_valid, req_ready           req_data (req_type)
//   rsp      out        rsp_valid, rsp_ready           rsp_data (rsp_type)
//
// an access is first compared in the cell row, then an update step ages the
// ranks, fills on a miss and loads the output register.
// a new access is taken once the update is done, so the next compare sees it.
// reset makes all ways invalid, ranks WAYS-1 down to 0 by way.
// a stalled result waits in the output register; while it waits and is not
// being taken, no new access is taken.
// ----------------------------------------------------------------------------
module fully_associative_lru_cache_tags_core
   import flru_pkg::*;
#(
   parameter int WAYS        = 4,
   parameter int OFFSET_BITS = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int TAG_BITS  = 32 - OFFSET_BITS;
   localparam int RANK_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

   logic                 req_fire;
   logic                 look_ff, look_in;
   logic                 kind_ff;
   logic [TAG_BITS-1:0]  tag_ff;
   logic [TAG_BITS-1:0]  lookup_tag;
   cell_ctl_type         ctl;
   cell_stat_type        stat_vec [WAYS];
   logic [RANK_BITS-1:0] rank_vec [WAYS];
   logic [WAYS-1:0]      match_vec;
   logic                 hit_any;
   logic [RANK_BITS-1:0] touch_rank;
   logic [RANK_BITS-1:0] touch_way;
   logic [31:0]          way_ext;
   logic [31:0]          access_ff, access_in;
   logic [31:0]          inst_hit_ff, inst_hit_in;
   logic [31:0]          data_hit_ff, data_hit_in;
   logic [31:0]          miss_ff, miss_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff;

   // input handshake
   assign req_ready  = ~look_ff & (~rsp_valid_ff | rsp_ready);
   assign req_fire   = req_valid & req_ready;
   assign lookup_tag = req_data.address[31:OFFSET_BITS];

   assign ctl.lookup = req_fire;
   assign ctl.commit = look_ff;
   assign ctl.hit    = hit_any;

   // row of way cells
   for (genvar g = 0; g < WAYS; g++) begin : g_way
      flru_cell #(
         .WAYS      (WAYS),
         .INDEX     (g),
         .TAG_BITS  (TAG_BITS),
         .RANK_BITS (RANK_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .lookup_tag (lookup_tag),
         .fill_tag   (tag_ff),
         .touch_rank (touch_rank),
         .stat       (stat_vec[g]),
         .rank       (rank_vec[g])
      );
      assign match_vec[g] = stat_vec[g].match;
   end

   assign hit_any = |match_vec;

   // rank and index of the touched way, exactly one cell touches
   always_comb begin
      touch_rank = '0;
      touch_way  = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (stat_vec[i].touch) begin
            touch_rank = touch_rank | rank_vec[i];
            touch_way  = touch_way | RANK_BITS'(i);
         end
      end
   end

   assign way_ext = 32'(touch_way);

   // counters and control next values
   always_comb begin
      look_in      = look_ff;
      access_in    = access_ff;
      inst_hit_in  = inst_hit_ff;
      data_hit_in  = data_hit_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (req_fire) begin
         look_in = 1'b1;
      end else if (look_ff) begin
         look_in = 1'b0;
      end
      if (look_ff) begin
         rsp_valid_in = 1'b1;
         access_in    = access_ff + 32'd1;
         if (!hit_any) begin
            miss_in = miss_ff + 32'd1;
         end else if (kind_ff == KIND_DATA) begin
            data_hit_in = data_hit_ff + 32'd1;
         end else begin
            inst_hit_in = inst_hit_ff + 32'd1;
         end
      end
   end

   // control and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         look_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         access_ff    <= '0;
         inst_hit_ff  <= '0;
         data_hit_ff  <= '0;
         miss_ff      <= '0;
      end else begin
         look_ff      <= look_in;
         rsp_valid_ff <= rsp_valid_in;
         access_ff    <= access_in;
         inst_hit_ff  <= inst_hit_in;
         data_hit_ff  <= data_hit_in;
         miss_ff      <= miss_in;
      end
   end

   // access payload and output register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_data.kind;
         tag_ff  <= lookup_tag;
      end
      if (look_ff) begin
         rsp_ff.hit            <= hit_any;
         rsp_ff.way            <= way_ext[1:0];
         rsp_ff.access_total   <= access_in;
         rsp_ff.inst_hit_total <= inst_hit_in;
         rsp_ff.data_hit_total <= data_hit_in;
         rsp_ff.miss_total     <= miss_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
